### design/gap_first_fit_task_placer_core_assert.svh
// Assertion shorthands for the task placer checker.
`ifndef GAP_FIRST_FIT_TASK_PLACER_CORE_ASSERT_SVH
`define GAP_FIRST_FIT_TASK_PLACER_CORE_ASSERT_SVH

// Consequent checked in the cycle after the antecedent.
`define GFTP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Consequent checked in the same cycle.
`define GFTP_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checked across reset itself.
`define GFTP_ASSERT_RESET(name, cons, msg) \
  name: assert property (@(posedge clk) rst |=> (cons)) \
    else $error(msg);

`endif

### design/gftp_pkg.sv
package gftp_pkg;

  localparam int MAX_EVENTS_DEF = 256;
  localparam int MAX_TASKS_DEF  = 64;
  localparam int TIME_BITS_DEF  = 48;

  localparam int FIELD_TIME_W = 48;
  localparam int DUR_W        = 32;
  localparam int IDX_W        = 6;
  localparam int FUNC_W       = 2;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_ADDR_W   = 4;

  localparam logic [FUNC_W-1:0] FUNC_BUSY = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TASK = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RUN  = 2'd2;

  // register index is paddr[3] (8-byte stride)
  localparam logic REG_BASE_TIME = 1'b0;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic [FIELD_TIME_W-1:0] event_begin;
    logic [FIELD_TIME_W-1:0] event_end;
    logic [FIELD_TIME_W-1:0] earliest_start;
    logic signed [DUR_W-1:0] duration;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        task_index;
    logic                    placed;
    logic [FIELD_TIME_W-1:0] slot_begin;
    logic [FIELD_TIME_W-1:0] slot_end;
    logic                    last;
  } result_t;

  // datapath commands
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NOP       = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
  localparam logic [OP_W-1:0] OP_KEY_RD    = 5'd2;
  localparam logic [OP_W-1:0] OP_KEY_LATCH = 5'd3;
  localparam logic [OP_W-1:0] OP_SHIFT     = 5'd4;
  localparam logic [OP_W-1:0] OP_PUT       = 5'd5;
  localparam logic [OP_W-1:0] OP_SW_RD0    = 5'd6;
  localparam logic [OP_W-1:0] OP_SW_FIRST  = 5'd7;
  localparam logic [OP_W-1:0] OP_GAP_PRE   = 5'd8;
  localparam logic [OP_W-1:0] OP_SW_NEXT   = 5'd9;
  localparam logic [OP_W-1:0] OP_SW_EVAL   = 5'd10;
  localparam logic [OP_W-1:0] OP_GAP_MID   = 5'd11;
  localparam logic [OP_W-1:0] OP_GAP_FINAL = 5'd12;
  localparam logic [OP_W-1:0] OP_GAP_BASE  = 5'd13;
  localparam logic [OP_W-1:0] OP_SW_ADV    = 5'd14;
  localparam logic [OP_W-1:0] OP_F_RD      = 5'd15;
  localparam logic [OP_W-1:0] OP_F_CHK     = 5'd16;
  localparam logic [OP_W-1:0] OP_F_FIT     = 5'd17;
  localparam logic [OP_W-1:0] OP_E_INIT    = 5'd18;
  localparam logic [OP_W-1:0] OP_E_RD      = 5'd19;
  localparam logic [OP_W-1:0] OP_E_LOAD    = 5'd20;
  localparam logic [OP_W-1:0] OP_E_NEXT    = 5'd21;
  localparam logic [OP_W-1:0] OP_DONE      = 5'd22;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic tc_zero;
    logic bc_zero;
    logic k_zero;
    logic k_one;
    logic key_less;
    logic i_last;
    logic pre_gap;
    logic gap_open;
    logic j_done;
    logic skip;
    logic out_taken;
  } status_t;

endpackage

### design/gftp_ram.sv
module gftp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/gftp_dp.sv
module gftp_dp #(
  parameter int MAX_EVENTS = 256,
  parameter int MAX_TASKS  = 64,
  parameter int TIME_BITS  = 48
) (
  input  logic              clk,
  input  logic              rst,
  input  gftp_pkg::item_t   item,
  input  logic [47:0]       base_time,
  input  gftp_pkg::cmd_t    cmd,
  output gftp_pkg::status_t status,
  output logic              result_valid,
  input  logic              result_stall,
  output gftp_pkg::result_t result
);
  import gftp_pkg::*;

  localparam int TB       = TIME_BITS;
  localparam int EP_W     = TB + 1;
  localparam int EP_DEPTH = 2 * MAX_EVENTS;
  localparam int BA_W     = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int TA_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int EA_W     = $clog2(EP_DEPTH);
  localparam int BC_W     = $clog2(MAX_EVENTS + 1);
  localparam int I_W      = $clog2(EP_DEPTH + 1);
  localparam int J_W      = $clog2(MAX_TASKS + 1);
  localparam int DEPTH_W  = $clog2(MAX_EVENTS + 1) + 1;
  localparam int SUM_W    = ((TB > DUR_W) ? TB : DUR_W) + 1;
  localparam logic [TB-1:0] TMAX = {TB{1'b1}};

  logic [BC_W-1:0]    bc;
  logic [J_W-1:0]     tc, j;
  logic [I_W-1:0]     i, k, total, km1, km2, ip1;
  logic [DEPTH_W-1:0] depth, depth_next;
  logic [EP_W-1:0]    key, ep_cur, ep_nxt, ep_rdata, ep_wdata;
  logic [EA_W-1:0]    ep_raddr;
  logic               ep_we;
  logic [2*TB-1:0]    busy_rdata;
  logic [TB+DUR_W-1:0] task_rdata;
  logic [TB-1:0]      ab_rdata;
  logic [TB-1:0]      base, gap_a, cur, close, m, m_next, task_start, ep_cur_max;
  logic [TB-1:0]      sat_a, sat_v;
  logic [DUR_W-1:0]   d, task_len, sat_d;
  logic [SUM_W-1:0]   sum, diff;
  logic               bounded, fits, load, busy_we, task_we, ab_we;
  logic [MAX_TASKS-1:0] flag;
  logic [TA_W-1:0]    ja;

  assign base  = TB'(base_time);
  assign load  = (cmd.op == OP_LOAD);
  assign total = I_W'({bc, 1'b0});
  assign km1   = k - I_W'(1);
  assign km2   = k - I_W'(2);
  assign ip1   = i + I_W'(1);
  assign ja    = j[TA_W-1:0];

  assign busy_we = load && (item.func == FUNC_BUSY) && (bc != BC_W'(MAX_EVENTS));
  assign task_we = load && (item.func == FUNC_TASK) && (tc != J_W'(MAX_TASKS));

  assign task_start = task_rdata[TB+DUR_W-1:DUR_W];
  assign task_len   = task_rdata[DUR_W-1:0];

  gftp_ram #(.WIDTH(2*TB), .DEPTH(MAX_EVENTS)) u_busy (
    .clk   (clk),
    .we    (busy_we),
    .waddr (bc[BA_W-1:0]),
    .wdata ({TB'(item.event_begin), TB'(item.event_end)}),
    .raddr (i[BA_W:1]),
    .rdata (busy_rdata)
  );

  gftp_ram #(.WIDTH(TB+DUR_W), .DEPTH(MAX_TASKS)) u_task (
    .clk   (clk),
    .we    (task_we),
    .waddr (tc[TA_W-1:0]),
    .wdata ({TB'(item.earliest_start), item.duration}),
    .raddr (ja),
    .rdata (task_rdata)
  );

  gftp_ram #(.WIDTH(EP_W), .DEPTH(EP_DEPTH)) u_ep (
    .clk   (clk),
    .we    (ep_we),
    .waddr (k[EA_W-1:0]),
    .wdata (ep_wdata),
    .raddr (ep_raddr),
    .rdata (ep_rdata)
  );

  gftp_ram #(.WIDTH(TB), .DEPTH(MAX_TASKS)) u_begin (
    .clk   (clk),
    .we    (ab_we),
    .waddr (ja),
    .wdata (m),
    .raddr (ja),
    .rdata (ab_rdata)
  );

  assign ep_we    = (cmd.op == OP_SHIFT) || (cmd.op == OP_PUT);
  assign ep_wdata = (cmd.op == OP_SHIFT) ? ep_rdata : key;

  always_comb begin
    unique case (cmd.op)
      OP_KEY_LATCH: ep_raddr = km1[EA_W-1:0];
      OP_SHIFT:     ep_raddr = km2[EA_W-1:0];
      OP_SW_NEXT:   ep_raddr = ip1[EA_W-1:0];
      default:      ep_raddr = '0;
    endcase
  end

  // shared saturating adder: fill uses (m, d), emit uses (stored begin, length)
  assign sat_a = (cmd.op == OP_E_LOAD) ? ab_rdata : m;
  assign sat_d = (cmd.op == OP_E_LOAD) ? task_len : d;
  assign sum   = SUM_W'(sat_a) + SUM_W'(sat_d);
  assign sat_v = (sum > SUM_W'(TMAX)) ? TMAX : sum[TB-1:0];

  assign diff  = SUM_W'(close) - SUM_W'(m);
  assign fits  = !bounded || ((m < close) && (SUM_W'(d) <= diff));
  assign ab_we = (cmd.op == OP_F_FIT) && fits;

  assign m_next     = (task_start > cur) ? task_start : cur;
  assign ep_cur_max = (ep_cur[EP_W-1:1] > base) ? ep_cur[EP_W-1:1] : base;
  assign depth_next = ep_cur[0] ? depth + DEPTH_W'(1) : depth - DEPTH_W'(1);

  always_comb begin
    status.tc_zero   = (tc == '0);
    status.bc_zero   = (bc == '0);
    status.k_zero    = (k == '0);
    status.k_one     = (k == I_W'(1));
    status.key_less  = (key < ep_rdata);
    status.i_last    = (ip1 == total);
    status.pre_gap   = (base < ep_rdata[EP_W-1:1]);
    status.gap_open  = (depth_next == '0) && (gap_a <= ep_rdata[EP_W-1:1]);
    status.j_done    = (j == tc);
    status.skip      = flag[ja] || task_len[DUR_W-1] || (task_len == '0);
    status.out_taken = result_valid && !result_stall;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      bc           <= '0;
      tc           <= '0;
      i            <= '0;
      k            <= '0;
      j            <= '0;
      depth        <= '0;
      flag         <= '0;
      bounded      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          if (busy_we) begin
            bc <= bc + BC_W'(1);
          end
          if (task_we) begin
            tc <= tc + J_W'(1);
          end
          if (item.func == FUNC_RUN) begin
            if (tc == '0) begin
              bc <= '0;
            end else begin
              flag <= '0;
              i    <= '0;
            end
          end
        end
        OP_KEY_RD:  k <= i;
        OP_SHIFT:   k <= km1;
        OP_PUT:     i <= ip1;
        OP_SW_RD0: begin
          i     <= '0;
          depth <= '0;
        end
        OP_SW_EVAL: depth <= depth_next;
        OP_GAP_MID: begin
          depth   <= depth_next;
          j       <= '0;
          bounded <= 1'b1;
        end
        OP_GAP_PRE: begin
          j       <= '0;
          bounded <= 1'b1;
        end
        OP_GAP_FINAL, OP_GAP_BASE: begin
          j       <= '0;
          bounded <= 1'b0;
        end
        OP_SW_ADV: i <= ip1;
        OP_F_CHK: begin
          if (status.skip) begin
            j <= j + J_W'(1);
          end
        end
        OP_F_FIT: begin
          if (fits) begin
            flag[ja] <= 1'b1;
          end
          j <= j + J_W'(1);
        end
        OP_E_INIT: j <= '0;
        OP_E_NEXT: j <= j + J_W'(1);
        OP_DONE: begin
          bc <= '0;
          tc <= '0;
        end
        default: ;
      endcase
      if (cmd.op == OP_E_LOAD) begin
        result_valid <= 1'b1;
      end else if (status.out_taken) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_KEY_LATCH: key <= i[0] ? {busy_rdata[TB-1:0], 1'b0} : {busy_rdata[2*TB-1:TB], 1'b1};
      OP_SW_FIRST:  ep_cur <= ep_rdata;
      OP_GAP_PRE: begin
        ep_cur <= ep_rdata;
        cur    <= base;
        close  <= ep_rdata[EP_W-1:1];
      end
      OP_SW_NEXT:   gap_a <= ep_cur_max;
      OP_SW_EVAL:   ep_nxt <= ep_rdata;
      OP_GAP_MID: begin
        ep_nxt <= ep_rdata;
        cur    <= gap_a;
        close  <= ep_rdata[EP_W-1:1];
      end
      OP_GAP_FINAL: cur <= ep_cur_max;
      OP_GAP_BASE:  cur <= base;
      OP_SW_ADV:    ep_cur <= ep_nxt;
      OP_F_CHK: begin
        m <= m_next;
        d <= task_len;
      end
      OP_F_FIT: begin
        if (fits) begin
          cur <= sat_v;
        end
      end
      OP_E_LOAD: begin
        result.task_index <= IDX_W'(j);
        result.placed     <= flag[ja];
        result.slot_begin <= flag[ja] ? FIELD_TIME_W'(ab_rdata) : '0;
        result.slot_end   <= flag[ja] ? FIELD_TIME_W'(sat_v) : '0;
        result.last       <= ((j + J_W'(1)) == tc);
      end
      default: ;
    endcase
  end

endmodule

### design/gftp_ctrl.sv
module gftp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic [1:0]        func,
  input  gftp_pkg::status_t status,
  output gftp_pkg::cmd_t    cmd,
  output logic              item_stall
);
  import gftp_pkg::*;

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] ST_IDLE     = 5'd0;
  localparam logic [ST_W-1:0] ST_RUN      = 5'd1;
  localparam logic [ST_W-1:0] ST_KEY_RD   = 5'd2;
  localparam logic [ST_W-1:0] ST_KEY      = 5'd3;
  localparam logic [ST_W-1:0] ST_CMP      = 5'd4;
  localparam logic [ST_W-1:0] ST_PUT      = 5'd5;
  localparam logic [ST_W-1:0] ST_SW0      = 5'd6;
  localparam logic [ST_W-1:0] ST_SW_FIRST = 5'd7;
  localparam logic [ST_W-1:0] ST_SW_NEXT  = 5'd8;
  localparam logic [ST_W-1:0] ST_SW_EVAL  = 5'd9;
  localparam logic [ST_W-1:0] ST_SW_ADV   = 5'd10;
  localparam logic [ST_W-1:0] ST_F_RD     = 5'd11;
  localparam logic [ST_W-1:0] ST_F_CHK    = 5'd12;
  localparam logic [ST_W-1:0] ST_F_FIT    = 5'd13;
  localparam logic [ST_W-1:0] ST_E_INIT   = 5'd14;
  localparam logic [ST_W-1:0] ST_E_RD     = 5'd15;
  localparam logic [ST_W-1:0] ST_E_LOAD   = 5'd16;
  localparam logic [ST_W-1:0] ST_E_WAIT   = 5'd17;

  logic [ST_W-1:0] state, state_next, ret, ret_next;

  assign item_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= ST_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    cmd.op     = OP_NOP;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.op = OP_LOAD;
          if (func == FUNC_RUN && !status.tc_zero) begin
            state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (status.bc_zero) begin
          cmd.op     = OP_GAP_BASE;
          ret_next   = ST_E_INIT;
          state_next = ST_F_RD;
        end else begin
          cmd.op     = OP_KEY_RD;
          state_next = ST_KEY;
        end
      end
      ST_KEY_RD: begin
        cmd.op     = OP_KEY_RD;
        state_next = ST_KEY;
      end
      ST_KEY: begin
        cmd.op     = OP_KEY_LATCH;
        state_next = status.k_zero ? ST_PUT : ST_CMP;
      end
      ST_CMP: begin
        if (status.key_less) begin
          cmd.op     = OP_SHIFT;
          state_next = status.k_one ? ST_PUT : ST_CMP;
        end else begin
          state_next = ST_PUT;
        end
      end
      ST_PUT: begin
        cmd.op     = OP_PUT;
        state_next = status.i_last ? ST_SW0 : ST_KEY_RD;
      end
      ST_SW0: begin
        cmd.op     = OP_SW_RD0;
        state_next = ST_SW_FIRST;
      end
      ST_SW_FIRST: begin
        if (status.pre_gap) begin
          cmd.op     = OP_GAP_PRE;
          ret_next   = ST_SW_NEXT;
          state_next = ST_F_RD;
        end else begin
          cmd.op     = OP_SW_FIRST;
          state_next = ST_SW_NEXT;
        end
      end
      ST_SW_NEXT: begin
        if (status.i_last) begin
          cmd.op     = OP_GAP_FINAL;
          ret_next   = ST_E_INIT;
          state_next = ST_F_RD;
        end else begin
          cmd.op     = OP_SW_NEXT;
          state_next = ST_SW_EVAL;
        end
      end
      ST_SW_EVAL: begin
        if (status.gap_open) begin
          cmd.op     = OP_GAP_MID;
          ret_next   = ST_SW_ADV;
          state_next = ST_F_RD;
        end else begin
          cmd.op     = OP_SW_EVAL;
          state_next = ST_SW_ADV;
        end
      end
      ST_SW_ADV: begin
        cmd.op     = OP_SW_ADV;
        state_next = ST_SW_NEXT;
      end
      ST_F_RD: begin
        if (status.j_done) begin
          state_next = ret;
        end else begin
          cmd.op     = OP_F_RD;
          state_next = ST_F_CHK;
        end
      end
      ST_F_CHK: begin
        cmd.op     = OP_F_CHK;
        state_next = status.skip ? ST_F_RD : ST_F_FIT;
      end
      ST_F_FIT: begin
        cmd.op     = OP_F_FIT;
        state_next = ST_F_RD;
      end
      ST_E_INIT: begin
        cmd.op     = OP_E_INIT;
        state_next = ST_E_RD;
      end
      ST_E_RD: begin
        if (status.j_done) begin
          cmd.op     = OP_DONE;
          state_next = ST_IDLE;
        end else begin
          cmd.op     = OP_E_RD;
          state_next = ST_E_LOAD;
        end
      end
      ST_E_LOAD: begin
        cmd.op     = OP_E_LOAD;
        state_next = ST_E_WAIT;
      end
      ST_E_WAIT: begin
        if (status.out_taken) begin
          cmd.op     = OP_E_NEXT;
          state_next = ST_E_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### design/gap_first_fit_task_placer_core.sv
// Load words (busy interval or task) are taken one per cycle while idle.
// A run word with tasks loaded sorts the 2N endpoints by insertion in the
// endpoint RAM, sweeps the sorted endpoints and scans the task RAM once per
// gap; the results then follow one at a time, each held until it is taken.
// Reset is synchronous: counts, placed flags, FSM and output valid clear;
// the interval, task, endpoint and slot RAMs hold no reset value.
module gap_first_fit_task_placer_core #(
  parameter int MAX_EVENTS = gftp_pkg::MAX_EVENTS_DEF,
  parameter int MAX_TASKS  = gftp_pkg::MAX_TASKS_DEF,
  parameter int TIME_BITS  = gftp_pkg::TIME_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input item channel
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  gftp_pkg::item_t                      item,
  // result channel
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output gftp_pkg::result_t                    result,
  // register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [gftp_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [gftp_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [gftp_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready
);
  import gftp_pkg::*;

  logic [FIELD_TIME_W-1:0] base_time;
  cmd_t                    cmd;
  status_t                 status;
  logic                    reg_sel;

  // one 64-bit register at byte 0; index is the 8-byte slot number
  assign reg_sel = (paddr[CFG_ADDR_W-1] == REG_BASE_TIME);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? CFG_DATA_W'(base_time) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_time <= '0;
    end else if (psel && penable && pwrite && reg_sel) begin
      base_time <= pwdata[FIELD_TIME_W-1:0];
    end
  end

  // sequencer: accepts words in idle, then steps sort, sweep, fill, emit
  gftp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .func       (item.func),
    .status     (status),
    .cmd        (cmd),
    .item_stall (item_stall)
  );

  // stores, counters, comparators and the result register
  gftp_dp #(
    .MAX_EVENTS (MAX_EVENTS),
    .MAX_TASKS  (MAX_TASKS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .base_time    (base_time),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

### design/gftp_checker.sv
`include "gap_first_fit_task_placer_core_assert.svh"

module gftp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            item_stall,
  input logic                            result_valid,
  input logic                            result_stall,
  input gftp_pkg::result_t               result
);

  `GFTP_ASSERT_RESET(a_reset_idle, !result_valid && !item_stall, "not idle after reset")

  `GFTP_ASSERT_NEXT(a_out_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result word changed")

  `GFTP_ASSERT_SAME(a_no_take_while_emit, result_valid, item_stall, "input taken during emit")

  `GFTP_ASSERT_NEXT(a_last_ends, result_valid && !result_stall && result.last, !result_valid, "word after last")

  `GFTP_ASSERT_SAME(a_unplaced_zero, result_valid && !result.placed, result.slot_begin == '0 && result.slot_end == '0, "unplaced slot not zero")

endmodule

bind gap_first_fit_task_placer_core gftp_checker u_gftp_checker (.*);

### tb/gap_first_fit_task_placer_core_tb.sv
`timescale 1ns / 100ps

import gftp_pkg::*;

// Scoreboard: keeps its own copy of the interval and task stores, computes the
// placement for each run word with tasks, holds the expected results in order.
class placement_board;
  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
  localparam int EV_MAX = 256;
  localparam int TK_MAX = 64;

  logic [47:0] base_time;
  logic [47:0] busy_from [EV_MAX];
  logic [47:0] busy_to   [EV_MAX];
  int          busy_n;
  logic [47:0] task_at   [TK_MAX];
  int          task_len  [TK_MAX];
  int          task_n;
  logic [47:0] ep_time   [2*EV_MAX];
  bit          ep_start  [2*EV_MAX];
  logic [47:0] slot_at   [TK_MAX];
  bit          slot_ok   [TK_MAX];
  result_t     slots_due [$];
  int          errors;
  int          checked;
  int          runs;

  function new();
    base_time = '0;
    busy_n = 0;
    task_n = 0;
    errors = 0;
    checked = 0;
    runs = 0;
  endfunction

  function logic [47:0] add_sat(logic [47:0] a, logic [63:0] d);
    logic [63:0] s;
    s = {16'd0, a} + d;
    return (s > {16'd0, TIME_MAX}) ? TIME_MAX : s[47:0];
  endfunction

  function bit ep_less(logic [47:0] ta, bit sa, logic [47:0] tb, bit sb);
    if (ta != tb) return ta < tb;
    return !sa && sb;
  endfunction

  // first fit by task index inside one gap
  function void fill_gap(logic [47:0] cur, logic [47:0] close, bit bounded);
    logic [47:0] m;
    logic [63:0] d;
    for (int j = 0; j < task_n; j++) begin
      if (slot_ok[j] || task_len[j] <= 0) continue;
      d = 64'(task_len[j]);
      m = (task_at[j] > cur) ? task_at[j] : cur;
      if (bounded && (m >= close || d > {16'd0, close - m})) continue;
      slot_ok[j] = 1;
      slot_at[j] = m;
      cur = add_sat(m, d);
    end
  endfunction

  function void place_all();
    int total, k, depth;
    logic [47:0] kt, a, b;
    bit ks;
    for (int i = 0; i < TK_MAX; i++) slot_ok[i] = 0;
    if (busy_n == 0) begin
      fill_gap(base_time, '0, 0);
      return;
    end
    total = 2 * busy_n;
    for (int i = 0; i < busy_n; i++) begin
      ep_time[2*i] = busy_from[i];   ep_start[2*i] = 1;
      ep_time[2*i+1] = busy_to[i];   ep_start[2*i+1] = 0;
    end
    for (int i = 1; i < total; i++) begin
      kt = ep_time[i];
      ks = ep_start[i];
      k = i;
      while (k > 0 && ep_less(kt, ks, ep_time[k-1], ep_start[k-1])) begin
        ep_time[k] = ep_time[k-1];
        ep_start[k] = ep_start[k-1];
        k--;
      end
      ep_time[k] = kt;
      ep_start[k] = ks;
    end
    if (base_time < ep_time[0]) fill_gap(base_time, ep_time[0], 1);
    depth = 0;
    for (int i = 0; i + 1 < total; i++) begin
      depth += ep_start[i] ? 1 : -1;
      if (depth == 0) begin
        a = ep_time[i];
        b = ep_time[i+1];
        if (a < base_time) a = base_time;
        if (a > b) continue;
        fill_gap(a, b, 1);
      end
    end
    a = ep_time[total-1];
    if (a < base_time) a = base_time;
    fill_gap(a, '0, 0);
  endfunction

  // called for every accepted input word
  function void note_word(item_t w);
    result_t r;
    case (w.func)
      FUNC_BUSY: begin
        if (busy_n < EV_MAX) begin
          busy_from[busy_n] = w.event_begin;
          busy_to[busy_n] = w.event_end;
          busy_n++;
        end
      end
      FUNC_TASK: begin
        if (task_n < TK_MAX) begin
          task_at[task_n] = w.earliest_start;
          task_len[task_n] = w.duration;
          task_n++;
        end
      end
      FUNC_RUN: begin
        if (task_n != 0) begin
          place_all();
          runs++;
          for (int j = 0; j < task_n; j++) begin
            r.task_index = IDX_W'(j);
            r.placed = slot_ok[j];
            r.slot_begin = slot_ok[j] ? slot_at[j] : '0;
            r.slot_end = slot_ok[j] ? add_sat(slot_at[j], 64'(task_len[j])) : '0;
            r.last = (j + 1 == task_n);
            slots_due.push_back(r);
          end
        end
        busy_n = 0;
        task_n = 0;
      end
      default: ;
    endcase
  endfunction

  function void check_result(result_t got);
    result_t e;
    checked++;
    if (slots_due.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual %p", $time, got);
      return;
    end
    e = slots_due.pop_front();
    if (got.task_index !== e.task_index) begin
      errors++;
      $display("%0t: task_index expected %0d actual %0d", $time, e.task_index, got.task_index);
    end
    if (got.placed !== e.placed) begin
      errors++;
      $display("%0t: placed expected %0d actual %0d (task %0d)", $time, e.placed, got.placed,
               e.task_index);
    end
    if (got.slot_begin !== e.slot_begin) begin
      errors++;
      $display("%0t: slot_begin expected %h actual %h (task %0d)", $time, e.slot_begin,
               got.slot_begin, e.task_index);
    end
    if (got.slot_end !== e.slot_end) begin
      errors++;
      $display("%0t: slot_end expected %h actual %h (task %0d)", $time, e.slot_end,
               got.slot_end, e.task_index);
    end
    if (got.last !== e.last) begin
      errors++;
      $display("%0t: last expected %0d actual %0d (task %0d)", $time, e.last, got.last,
               e.task_index);
    end
  endfunction
endclass

module gap_first_fit_task_placer_core_tb;
  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;      // unused code, block ignores it
  localparam logic [CFG_ADDR_W-1:0] BASE_TIME_ADDR = {REG_BASE_TIME, 3'b000};
  localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int SETTLE = 100;                         // idle cycles after last result
  localparam int WORD_TARGET = 360;

  logic clk, rst;
  logic item_valid, item_stall;
  item_t item;
  logic result_valid, result_stall;
  result_t result;
  logic psel, penable, pwrite, pready;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata, prdata;

  placement_board board;
  int cycles;
  int words_sent;
  int hold_req;     // long receiver hold, in cycles; picked up by the stall process
  bit quiet;        // no idling on either side

  gap_first_fit_task_placer_core dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               board.slots_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // result monitor: sampled values at the edge are the ones the block saw
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) board.check_result(result);
  end

  // receiver stall: random bursts, or one long hold on request
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 0;
      stall_left = 0;
    end else if (hold_req > 0) begin
      result_stall <= 1;
      hold_req--;
    end else if (quiet) begin
      result_stall <= 0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= (stall_left != 0);
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 10);
      result_stall <= 1;
    end else begin
      result_stall <= 0;
    end
  end

  // one word on the input channel; idle burst first at random
  task automatic send_word(item_t w);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      item_valid <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    item_valid <= 1;
    item <= w;
    do @(posedge clk); while (item_stall);
    board.note_word(w);
    words_sent++;
  endtask

  task automatic go_idle();
    item_valid <= 0;
    item <= '0;
  endtask

  task automatic send_busy(logic [47:0] b, logic [47:0] e);
    item_t w;
    w = '0;
    w.func = FUNC_BUSY;
    w.event_begin = b;
    w.event_end = e;
    w.earliest_start = 48'({$urandom, $urandom});  // ignored field, toggled anyway
    send_word(w);
  endtask

  task automatic send_task(logic [47:0] s, int d);
    item_t w;
    w = '0;
    w.func = FUNC_TASK;
    w.earliest_start = s;
    w.duration = d;
    w.event_begin = 48'({$urandom, $urandom});
    send_word(w);
  endtask

  task automatic send_func(logic [FUNC_W-1:0] f);
    item_t w;
    logic [191:0] rnd;
    rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};  // payload ignored
    w = rnd[$bits(item_t)-1:0];
    w.func = f;
    send_word(w);
  endtask

  // sender stops until every expected result is in, then lets the block settle
  task automatic drain();
    go_idle();
    while (board.slots_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register write: setup then access; caller has drained the block
  task automatic write_base(logic [47:0] v);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= BASE_TIME_ADDR;
    pwdata <= {16'd0, v};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    board.base_time = v;
  endtask

  function automatic logic [47:0] pick_time(logic [47:0] lo, int span);
    logic [47:0] t;
    if ($urandom_range(0, 19) == 0) return 48'({$urandom, $urandom});
    t = lo + $urandom_range(0, span);
    return (t < lo) ? TMAX : t;    // stay clear of wraparound near the top
  endfunction

  function automatic int pick_len();
    case ($urandom_range(0, 19))
      0:       return -$urandom_range(0, 100);
      1:       return 0;
      2:       return $urandom;                  // full 32 bits, either sign
      3:       return 32'h7FFF_FFFF;
      default: return $urandom_range(1, 60);
    endcase
  endfunction

  // one well-formed batch with random content
  task automatic random_batch(int max_busy, int max_tasks);
    logic [47:0] lo, a, b;
    int nb, nt;
    case ($urandom_range(0, 7))
      0:       lo = TMAX - 48'd400;
      1:       lo = 48'({$urandom, $urandom});
      default: lo = 48'($urandom_range(0, 200));
    endcase
    if (lo > TMAX - 48'd400) lo = TMAX - 48'd400;
    nb = $urandom_range(0, max_busy);
    nt = $urandom_range(1, max_tasks);
    // loads are interleaved in random order
    while (nb + nt > 0) begin
      if (nb > 0 && (nt == 0 || $urandom_range(0, 1))) begin
        a = pick_time(lo, 300);
        b = ($urandom_range(0, 9) == 0) ? pick_time(lo, 300) : a + $urandom_range(0, 40);
        if (b < a && $urandom_range(0, 9) != 0) b = a;
        send_busy(a, b);
        nb--;
      end else begin
        send_task(pick_time(lo, 300), pick_len());
        nt--;
      end
    end
    if ($urandom_range(0, 15) == 0) send_func(FUNC_NONE);
    send_func(FUNC_RUN);
  endtask

  initial begin
    board = new();
    cycles = 0;
    words_sent = 0;
    hold_req = 0;
    quiet = 0;
    rst = 1;
    item_valid = 0;
    item = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, odd durations, reversed interval, unknown func
    write_base(48'd0);
    send_busy(48'd10, 48'd20);
    send_busy(48'd20, 48'd30);           // touching intervals, end sorts before start
    send_busy(48'd50, 48'd40);           // reversed
    send_task(48'd0, 10);
    send_task(48'd0, 0);                 // never placed
    send_task(48'd0, 32'sh8000_0000);    // most negative
    send_task(48'd35, 5);
    send_task(48'd29, 1);                // late for the earlier gap
    send_func(FUNC_NONE);
    send_task(TMAX, 32'sh7FFF_FFFF);     // saturated end
    send_func(FUNC_RUN);
    send_func(FUNC_RUN);                 // no tasks: nothing comes back
    send_task(48'd5, 3);                 // no intervals: whole future is free
    send_task(48'd0, 4);
    send_func(FUNC_RUN);
    send_busy(48'd0, TMAX);
    send_task(48'd0, 1);
    send_func(FUNC_RUN);
    drain();

    write_base(TMAX);
    send_busy(48'd100, 48'd200);
    send_task(48'd0, 1);
    send_task(TMAX, 2);
    send_func(FUNC_RUN);
    drain();

    // full task store plus one extra; receiver holds off while loads keep coming
    write_base(48'd7);
    for (int i = 0; i < 65; i++) send_task(48'($urandom_range(0, 500)), $urandom_range(1, 20));
    send_func(FUNC_RUN);
    hold_req = 400;
    for (int i = 0; i < 3; i++) random_batch(4, 6);
    drain();

    // many intervals, a long sort
    write_base(48'd300);
    for (int i = 0; i < 40; i++) begin
      logic [47:0] a;
      a = 48'($urandom_range(0, 2000));
      send_busy(a, a + 48'($urandom_range(0, 30)));
    end
    send_task(48'd0, 5);
    send_task(48'd1000, 2);
    send_func(FUNC_RUN);
    drain();

    // random batches over several base times
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_base(48'd0);
        1: write_base(48'd120);
        2: write_base(48'({$urandom, $urandom}));
        default: write_base(TMAX - 48'd200);
      endcase
      for (int i = 0; i < 3; i++) random_batch(8, 10);
      drain();
    end

    // last part: no idling on either side
    write_base(48'd60);
    quiet = 1;
    while (words_sent < WORD_TARGET) random_batch(8, 10);
    drain();

    $display("%0d words sent, %0d placement runs, %0d results checked", words_sent,
             board.runs, board.checked);
    $display("covered a full task store, a long sort, reversed and touching intervals, "
             , "saturation, base extremes");
    if (board.errors == 0 && board.slots_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results never seen", board.errors, board.slots_due.size());
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

### files.f
+incdir+design
design/gftp_pkg.sv
design/gftp_ram.sv
design/gftp_dp.sv
design/gftp_ctrl.sv
design/gap_first_fit_task_placer_core.sv
design/gftp_checker.sv
tb/gap_first_fit_task_placer_core_tb.sv
